@@ rtl/pfpw_pkg.sv @@
// Shared types, constants and the fixed register table for the PLL frequency-plan writer.
// Used by the channel interfaces, the controller, the datapath and the top level.
package pfpw_pkg;

    // Field widths
    localparam int TARGET_W = 19;
    localparam int CH_W     = 2;
    localparam int WORD_W   = 32;
    localparam int DLY_W    = 2;

    localparam int MAX_DIV_INDEX_DEF = 18;

    // Frequency plan, 10 kHz units
    localparam int VCO_LOW     = 188000;
    localparam int VCO_HIGH    = 376000;
    localparam int PFD_UNITS   = 3072;
    localparam int FRAC_DEN    = 32'h002E_E000;
    localparam int NUM_SCALE   = FRAC_DEN / PFD_UNITS;  // remainder to numerator
    localparam int RECIP_3     = 171;                   // floor(x/3) = (x*171)>>9 for x < 512
    localparam int PFD_SHIFT   = 10;                    // 3072 = 3 << 10
    localparam int VCO_IN_W    = 19;                    // in-window VCO fits here
    localparam int PLL_N_W     = 7;
    localparam int REM_W       = 12;
    localparam int NUM_W       = 22;
    localparam int DIV_FIELD_W = 5;

    // Sequence layout
    localparam int WORD_COUNT = 15;
    localparam int SLOT_W     = 4;
    localparam logic [SLOT_W-1:0] SLOT_FIRST = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_R5    = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_R4    = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_R3    = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_R2    = 4'd11;
    localparam logic [SLOT_W-1:0] SLOT_R1    = 4'd12;
    localparam logic [SLOT_W-1:0] SLOT_R0A   = 4'd13;
    localparam logic [SLOT_W-1:0] SLOT_R0B   = 4'd14;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = 4'(WORD_COUNT - 1);

    // Delay hint codes
    localparam logic [DLY_W-1:0] DLY_NONE  = 2'd0;
    localparam logic [DLY_W-1:0] DLY_SHORT = 2'd1;
    localparam logic [DLY_W-1:0] DLY_LONG  = 2'd2;

    // Register words
    localparam logic [WORD_W-1:0] R5_DIRECT  = 32'h0010_8005;
    localparam logic [WORD_W-1:0] R5_DIVIDED = 32'h0010_A805;
    localparam logic [WORD_W-1:0] R4_WORD    = 32'h0000_0004;
    localparam logic [WORD_W-1:0] R3_BASE    = 32'h2000_0FE3;
    localparam logic [WORD_W-1:0] R2_WORD    = 32'h0C00_0002 | (32'(FRAC_DEN) << 4);
    localparam logic [WORD_W-1:0] R1_BASE    = 32'h7000_2021;
    localparam logic [WORD_W-1:0] R0_BASE    = 32'h4000_0000;

    localparam logic [WORD_W-1:0] HEAD_WORDS [8] = '{
        32'h0010_8015, 32'h021F_E80F, 32'h4082_C10D, 32'h2100_50CA,
        32'h03C7_C039, 32'h207D_DBF8, 32'h0008_2317, 32'h0000_04C6
    };

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture a new request
        logic step;       // try next divisor
        logic fail;       // no divisor fits
        logic quot;       // integer N
        logic rem;        // remainder
        logic num;        // fractional numerator
        logic emit_next;  // advance to next word
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_window;
        logic search_end;
        logic emit_last;
    } t_status;

endpackage

@@ rtl/pfpw_if.sv @@
// Valid/ready channel interfaces for requests and register-word results.
// Depends on pfpw_pkg for field widths.
interface pfpw_in_if;
    import pfpw_pkg::*;
    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] target_freq;
    logic [CH_W-1:0]     channel;

    modport source (output valid, output target_freq, output channel, input ready);
    modport sink   (input valid, input target_freq, input channel, output ready);
endinterface

interface pfpw_out_if;
    import pfpw_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] spi_word;
    logic [CH_W-1:0]   channel_out;
    logic [DLY_W-1:0]  delay_after;
    logic              range_error;
    logic              last_word;

    modport source (output valid, output spi_word, output channel_out, output delay_after,
                    output range_error, output last_word, input ready);
    modport sink   (input valid, input spi_word, input channel_out, input delay_after,
                    input range_error, input last_word, output ready);
endinterface

@@ rtl/pfpw_ctrl.sv @@
// Sequencer for the frequency-plan writer: search, plan arithmetic, word emission.
// Depends on pfpw_pkg for the command and status structs.
module pfpw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pfpw_pkg::t_status i_status,
    output pfpw_pkg::t_cmd    o_cmd
);
    import pfpw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_QUOT, S_REM, S_NUM, S_EMIT, S_ERR
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, r_out_valid;
    logic   w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && r_in_ready;
    assign w_out_acc = r_out_valid && i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_status.in_window) begin
                    n_state = S_QUOT;
                end else if (i_status.search_end) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_ERR;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_QUOT: begin
                o_cmd.quot = 1'b1;
                n_state    = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = S_NUM;
            end
            S_NUM: begin
                o_cmd.num = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                    end
                end
            end
            S_ERR: begin
                if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_IDLE);
            r_out_valid <= (n_state == S_EMIT) || (n_state == S_ERR);
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/pfpw_dp.sv @@
// Datapath: divisor search accumulator, N / remainder / numerator, word selection.
// Depends on pfpw_pkg for constants, the register table and command/status structs.
module pfpw_dp #(
    parameter int MAX_DIV_INDEX = pfpw_pkg::MAX_DIV_INDEX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfpw_pkg::t_cmd                i_cmd,
    input  logic [pfpw_pkg::TARGET_W-1:0] i_target_freq,
    input  logic [pfpw_pkg::CH_W-1:0]     i_channel,
    output pfpw_pkg::t_status             o_status,
    output logic [pfpw_pkg::WORD_W-1:0]   o_spi_word,
    output logic [pfpw_pkg::CH_W-1:0]     o_channel_out,
    output logic [pfpw_pkg::DLY_W-1:0]    o_delay_after,
    output logic                          o_range_error,
    output logic                          o_last_word
);
    import pfpw_pkg::*;

    localparam int IDX_W = (MAX_DIV_INDEX > 1) ? $clog2(MAX_DIV_INDEX + 1) : 1;
    // (2*MAX+2)*freq < 2^(TARGET_W+1+clog2(MAX+1))
    localparam int VCO_W = TARGET_W + 1 + IDX_W;

    logic [VCO_W-1:0]   r_vco, r_mult2;
    logic [IDX_W-1:0]   r_idx;
    logic               r_divided, r_err;
    logic [CH_W-1:0]    r_chan;
    logic [PLL_N_W-1:0] r_pll_n;
    logic [REM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_num;
    logic [SLOT_W-1:0]  r_slot;

    logic [VCO_IN_W-PFD_SHIFT-1:0] w_hi;
    logic [VCO_IN_W-PFD_SHIFT+7:0] w_quot_prod;
    logic [VCO_IN_W-1:0]           w_rem_full;
    logic [DIV_FIELD_W-1:0]        w_div_field;
    logic [WORD_W-1:0]             w_r0, w_r1, w_r3, w_r5, w_word;

    // Search, arithmetic and sequence counter
    assign w_hi        = r_vco[VCO_IN_W-1:PFD_SHIFT];
    assign w_quot_prod = (VCO_IN_W-PFD_SHIFT+8)'(w_hi) * (VCO_IN_W-PFD_SHIFT+8)'(RECIP_3);
    assign w_rem_full  = r_vco[VCO_IN_W-1:0]
                       - (VCO_IN_W'(r_pll_n) * VCO_IN_W'(PFD_UNITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err  <= 1'b0;
            r_slot <= SLOT_FIRST;
        end else begin
            if (i_cmd.load) begin
                r_err  <= 1'b0;
                r_slot <= SLOT_FIRST;
            end else begin
                if (i_cmd.fail)      r_err  <= 1'b1;
                if (i_cmd.emit_next) r_slot <= r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vco     <= VCO_W'(i_target_freq);
            r_mult2   <= VCO_W'({i_target_freq, 1'b0});
            r_idx     <= '0;
            r_divided <= 1'b0;
            r_chan    <= i_channel;
        end else if (i_cmd.step) begin
            // first step moves to x2, later steps add 2*freq and bump the index
            if (!r_divided) begin
                r_vco     <= r_mult2;
                r_divided <= 1'b1;
            end else begin
                r_vco <= r_vco + r_mult2;
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.quot) r_pll_n <= w_quot_prod[VCO_IN_W-PFD_SHIFT+8-2:9];
        if (i_cmd.rem)  r_rem   <= w_rem_full[REM_W-1:0];
        if (i_cmd.num)  r_num   <= NUM_W'(r_rem) * NUM_W'(NUM_SCALE);
    end

    assign o_status.in_window  = (r_vco >= VCO_W'(VCO_LOW)) && (r_vco <= VCO_W'(VCO_HIGH));
    assign o_status.search_end = r_divided && (r_idx == IDX_W'(MAX_DIV_INDEX));
    assign o_status.emit_last  = (r_slot == SLOT_LAST);

    // Patched words
    assign w_div_field = DIV_FIELD_W'(r_idx);
    assign w_r5 = r_divided ? R5_DIVIDED : R5_DIRECT;
    assign w_r3 = R3_BASE | (WORD_W'(w_div_field) << 18);
    assign w_r1 = R1_BASE | (WORD_W'(r_num[NUM_W-1:12]) << 15);
    assign w_r0 = R0_BASE | (WORD_W'(r_pll_n) << 16) | (WORD_W'(r_num[11:0]) << 4);

    always_comb begin
        case (r_slot)
            SLOT_R5:            w_word = w_r5;
            SLOT_R4:            w_word = R4_WORD;
            SLOT_R3:            w_word = w_r3;
            SLOT_R2:            w_word = R2_WORD;
            SLOT_R1:            w_word = w_r1;
            SLOT_R0A, SLOT_R0B: w_word = w_r0;
            default: begin
                if (r_slot < SLOT_R5) w_word = HEAD_WORDS[r_slot[2:0]];
                else                  w_word = '0;
            end
        endcase
    end

    // Beat payload
    always_comb begin
        if (r_err)                    o_delay_after = DLY_NONE;
        else if (r_slot == SLOT_FIRST) o_delay_after = DLY_SHORT;
        else if (r_slot == SLOT_R0A)   o_delay_after = DLY_LONG;
        else                          o_delay_after = DLY_NONE;
    end

    assign o_spi_word    = r_err ? '0 : w_word;
    assign o_channel_out = r_chan;
    assign o_range_error = r_err;
    assign o_last_word   = r_err || (r_slot == SLOT_LAST);

endmodule

@@ rtl/pll_frequency_plan_writer.sv @@
// PLL frequency-plan writer: one request in, 15 register-word beats out (or one error beat).
// Divisor search tries one divisor per cycle in the accumulator; N, remainder and numerator
// follow in turn, then 15 beats go out at one per cycle while the sink is ready.
// One request at a time; the next is taken the cycle after the last beat is accepted.
// Synchronous active-low reset returns the sequencer to idle; no memory clearing.
module pll_frequency_plan_writer #(
    parameter int MAX_DIV_INDEX = pfpw_pkg::MAX_DIV_INDEX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfpw_in_if.sink    i_in,
    pfpw_out_if.source o_out
);
    import pfpw_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    pfpw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pfpw_dp #(
        .MAX_DIV_INDEX (MAX_DIV_INDEX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_target_freq (i_in.target_freq),
        .i_channel     (i_in.channel),
        .o_status      (w_status),
        .o_spi_word    (o_out.spi_word),
        .o_channel_out (o_out.channel_out),
        .o_delay_after (o_out.delay_after),
        .o_range_error (o_out.range_error),
        .o_last_word   (o_out.last_word)
    );

    // No request taken while beats are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("request ready while beats pending");

    // An error beat is a lone, empty, final beat
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.range_error) |-> (o_out.last_word && (o_out.spi_word == '0)))
        else $error("malformed error beat");

    // Final beat accepted returns to idle
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> i_in.ready)
        else $error("not idle after last beat");

    // Step, fail and emit-next commands are never issued together with a new request capture
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !(w_cmd.step || w_cmd.fail || w_cmd.emit_next))
        else $error("load overlaps other command");

endmodule
